/* rtl/tlj_pkg.sv */
// Shared package for the text line justifier.
// Field widths, reset values, controller state encoding and the result record.
// No dependencies.
`default_nettype none

package tlj_pkg;

    localparam int LEN_W          = 6;
    localparam int NUM_W          = 16;
    localparam int LINE_WORDS_DEF = 32;

    localparam logic [LEN_W-1:0] WIDTH_RESET = LEN_W'(16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FL_INIT,
        S_FL_DIV,
        S_FL_RD,
        S_FL_EMIT,
        S_PLACE,
        S_DROP
    } tlj_state_t;

    typedef struct packed {
        logic [NUM_W-1:0] word_number;
        logic [LEN_W-1:0] placed_length;
        logic [LEN_W-1:0] spaces_after;
        logic             line_end;
        logic             final_line;
        logic             too_long;
        logic             last_of_run;
    } tlj_result_t;

endpackage

`default_nettype wire

/* rtl/tlj_if.sv */
// Valid/ready channel interfaces for the text line justifier.
// tlj_word_if carries input words, tlj_result_if carries placed words.
// Depends on tlj_pkg.
`default_nettype none

interface tlj_word_if;
    import tlj_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] word_length;
    logic             last_word;

    modport source (output valid, word_length, last_word, input ready);
    modport sink   (input valid, word_length, last_word, output ready);
endinterface

interface tlj_result_if;
    import tlj_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] word_number;
    logic [LEN_W-1:0] placed_length;
    logic [LEN_W-1:0] spaces_after;
    logic             line_end;
    logic             final_line;
    logic             too_long;
    logic             last_of_run;

    modport source (output valid, word_number, placed_length, spaces_after, line_end,
                    final_line, too_long, last_of_run, input ready);
    modport sink   (input valid, word_number, placed_length, spaces_after, line_end,
                    final_line, too_long, last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/tlj_lbuf.sv */
// Word length buffer: one write port, one read port, registered read data.
// Depends on tlj_pkg.
`default_nettype none

module tlj_lbuf #(
    parameter int DEPTH = tlj_pkg::LINE_WORDS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [tlj_pkg::LEN_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [tlj_pkg::LEN_W-1:0] rdata
);
    import tlj_pkg::*;

    logic [LEN_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tlj_div.sv */
// Restoring divider, one quotient bit per cycle, for the gap spacing split.
// Depends on tlj_pkg.
`default_nettype none

module tlj_div #(
    parameter int DVS_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tlj_pkg::LEN_W-1:0] dividend,
    input  wire logic [DVS_W-1:0]          divisor,
    output logic                           done,
    output logic      [tlj_pkg::LEN_W-1:0] quotient,
    output logic      [DVS_W-1:0]          remainder
);
    import tlj_pkg::*;

    localparam int STEP_W = $clog2(LEN_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    rem_reg, rem_next;
    logic [DVS_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg[DVS_W-1:0], dvd_reg[LEN_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(LEN_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (trial - {1'b0, dvs_reg}) : trial;
            dvd_next  = {dvd_reg[LEN_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            busy_next = step_reg != STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (step_reg == STEP_W'(1));
    assign quotient  = dvd_reg;
    assign remainder = rem_reg[DVS_W-1:0];

endmodule

`default_nettype wire

/* rtl/text_line_justifier_unit.sv */
// Greedy full text justifier: top level with controller and result register.
// Depends on tlj_pkg, tlj_if (tlj_word_if, tlj_result_if), tlj_lbuf, tlj_div.
//
// Usage:
//   words   : valid/ready sink of word lengths; last_word flushes the last line.
//   results : valid/ready source, one transfer per placed or dropped word.
//   cfg_we/cfg_data : writes line_width; write only while the block is idle.
// A word that fits and causes no flush is accepted in S_IDLE and written to
// the buffer in S_PLACE. A line flush runs a setup state (S_FL_INIT), then
// the serial divider (S_FL_DIV) when the line is fully justified with two or
// more words, then a buffer read (S_FL_RD) and a result load (S_FL_EMIT) for
// each word. One word is handled at a time; words.ready is high only when idle.
// Results sit in a single output register; a stalled receiver holds the
// controller at the next result, and a word may be accepted while the final
// result of the previous one is still waiting.
// Reset clears the line, the word numbering and sets line_width to 16; the
// buffer contents are not cleared and need no clearing pass.
`default_nettype none

module text_line_justifier_unit #(
    parameter int LINE_WORDS = tlj_pkg::LINE_WORDS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tlj_pkg::LEN_W-1:0] cfg_data,
    tlj_word_if.sink                       words,
    tlj_result_if.source                   results
);
    import tlj_pkg::*;

    localparam int CNT_W = $clog2(LINE_WORDS + 1);
    localparam int AW    = $clog2(LINE_WORDS);
    localparam int SUM_W = LEN_W + 2;
    localparam int XW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    tlj_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  width_reg, width_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  chars_reg, chars_next;
    logic [NUM_W-1:0]  start_reg, start_next;
    logic [NUM_W-1:0]  nextnum_reg, nextnum_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [LEN_W-1:0]  extra_reg, extra_next;
    logic [LEN_W-1:0]  w_reg, w_next;
    logic              last_reg, last_next;
    logic              drop_reg, drop_next;
    logic              final_reg, final_next;
    logic              res_valid_reg, res_valid_next;
    tlj_result_t       res_reg, res_next;

    logic              accept;
    logic              drop_in;
    logic              need_flush;
    logic [SUM_W-1:0]  fit_sum;
    logic              slot_free;
    logic              load_flush;
    logic              load_drop;
    logic [CNT_W-1:0]  gaps;
    logic              last_j;
    logic [LEN_W-1:0]  extra_now;
    logic [XW-1:0]     pad_diff;
    logic [LEN_W-1:0]  sp;

    logic              mem_we;
    logic              mem_re;
    logic [LEN_W-1:0]  mem_rdata;

    logic              div_start;
    logic              div_done;
    logic [LEN_W-1:0]  div_q;
    logic [CNT_W-1:0]  div_r;

    tlj_lbuf #(
        .DEPTH (LINE_WORDS)
    ) u_lbuf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (w_reg),
        .re    (mem_re),
        .raddr (j_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    tlj_div #(
        .DVS_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (extra_now),
        .divisor   (gaps),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign words.ready = (state_reg == S_IDLE);
    assign accept      = words.valid && words.ready;
    assign drop_in     = (words.word_length == '0) || (words.word_length > width_reg);
    assign fit_sum     = SUM_W'(chars_reg) + SUM_W'(count_reg) + SUM_W'(words.word_length);
    assign need_flush  = (count_reg != '0)
                         && ((fit_sum > SUM_W'(width_reg))
                             || (count_reg >= CNT_W'(LINE_WORDS)));
    assign slot_free   = !res_valid_reg || results.ready;
    assign load_flush  = (state_reg == S_FL_EMIT) && slot_free;
    assign load_drop   = (state_reg == S_DROP) && slot_free;
    assign gaps        = count_reg - CNT_W'(1);
    assign last_j      = (j_reg == gaps);
    assign extra_now   = (width_reg >= chars_reg) ? (width_reg - chars_reg) : '0;
    assign pad_diff    = XW'(extra_reg) - XW'(gaps);

    // spacing after word j of the line being flushed
    always_comb
    begin
        if (final_reg)
        begin
            if (!last_j)
            begin
                sp = LEN_W'(1);
            end
            else if (XW'(extra_reg) >= XW'(gaps))
            begin
                sp = LEN_W'(pad_diff);
            end
            else
            begin
                sp = '0;
            end
        end
        else if (count_reg == CNT_W'(1))
        begin
            sp = extra_reg;
        end
        else if (last_j)
        begin
            sp = '0;
        end
        else
        begin
            sp = div_q + ((j_reg < div_r) ? LEN_W'(1) : LEN_W'(0));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (drop_in)
                    begin
                        state_next = (words.last_word && count_reg != '0) ? S_FL_INIT : S_DROP;
                    end
                    else
                    begin
                        state_next = need_flush ? S_FL_INIT : S_PLACE;
                    end
                end
            end
            S_FL_INIT:
            begin
                state_next = div_start ? S_FL_DIV : S_FL_RD;
            end
            S_FL_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FL_RD;
                end
            end
            S_FL_RD:
            begin
                state_next = S_FL_EMIT;
            end
            S_FL_EMIT:
            begin
                if (load_flush)
                begin
                    if (!last_j)
                    begin
                        state_next = S_FL_RD;
                    end
                    else if (!final_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = drop_reg ? S_DROP : S_IDLE;
                    end
                end
            end
            S_PLACE:
            begin
                state_next = last_reg ? S_FL_INIT : S_IDLE;
            end
            S_DROP:
            begin
                if (load_drop)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        width_next     = cfg_we ? cfg_data : width_reg;
        count_next     = count_reg;
        chars_next     = chars_reg;
        start_next     = start_reg;
        nextnum_next   = nextnum_reg;
        j_next         = j_reg;
        extra_next     = extra_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        drop_next      = drop_reg;
        final_next     = final_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !results.ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    w_next     = words.word_length;
                    last_next  = words.last_word;
                    drop_next  = drop_in;
                    final_next = drop_in;
                end
            end
            S_FL_INIT:
            begin
                extra_next = extra_now;
                j_next     = '0;
                div_start  = !final_reg && (count_reg >= CNT_W'(2));
            end
            S_FL_RD:
            begin
                mem_re = 1'b1;
            end
            S_FL_EMIT:
            begin
                if (load_flush)
                begin
                    res_valid_next        = 1'b1;
                    res_next.word_number  = start_reg + NUM_W'(j_reg);
                    res_next.placed_length = mem_rdata;
                    res_next.spaces_after = sp;
                    res_next.line_end     = last_j;
                    res_next.final_line   = final_reg;
                    res_next.too_long     = 1'b0;
                    res_next.last_of_run  = last_j && (final_reg ? !drop_reg : !last_reg);
                    if (last_j)
                    begin
                        count_next = '0;
                        chars_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                end
            end
            S_PLACE:
            begin
                mem_we       = 1'b1;
                count_next   = count_reg + CNT_W'(1);
                chars_next   = chars_reg + w_reg;
                nextnum_next = nextnum_reg + NUM_W'(1);
                final_next   = last_reg;
                if (count_reg == '0)
                begin
                    start_next = nextnum_reg;
                end
            end
            S_DROP:
            begin
                if (load_drop)
                begin
                    res_valid_next         = 1'b1;
                    res_next.word_number   = nextnum_reg;
                    res_next.placed_length = w_reg;
                    res_next.spaces_after  = '0;
                    res_next.line_end      = 1'b0;
                    res_next.final_line    = 1'b0;
                    res_next.too_long      = 1'b1;
                    res_next.last_of_run   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            count_reg     <= '0;
            chars_reg     <= '0;
            start_reg     <= '0;
            nextnum_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            count_reg     <= count_next;
            chars_reg     <= chars_next;
            start_reg     <= start_next;
            nextnum_reg   <= nextnum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        extra_reg <= extra_next;
        w_reg     <= w_next;
        last_reg  <= last_next;
        drop_reg  <= drop_next;
        final_reg <= final_next;
        res_reg   <= res_next;
    end

    assign results.valid         = res_valid_reg;
    assign results.word_number   = res_reg.word_number;
    assign results.placed_length = res_reg.placed_length;
    assign results.spaces_after  = res_reg.spaces_after;
    assign results.line_end      = res_reg.line_end;
    assign results.final_line    = res_reg.final_line;
    assign results.too_long      = res_reg.too_long;
    assign results.last_of_run   = res_reg.last_of_run;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LINE_WORDS))
        else $error("line word count beyond buffer depth");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_INIT) |-> (count_reg != '0))
        else $error("flush started on an empty line");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < CNT_W'(LINE_WORDS)))
        else $error("buffer write beyond depth");

    a_emit_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        load_flush |-> (j_reg < count_reg))
        else $error("flush index beyond line");

    a_div_before_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_DIV && div_done) |=> (state_reg == S_FL_RD))
        else $error("divider result not followed by buffer read");

endmodule

`default_nettype wire

/* bench/tlj_justify_checker.sv */
// Prediction and comparison for the text line justifier.
// Watches word and result transfers plus the width register writes.
// Depends on tlj_pkg and tlj_if.

module tlj_justify_checker #(
    parameter int LINE_WORDS = tlj_pkg::LINE_WORDS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tlj_pkg::LEN_W-1:0] cfg_data,
    tlj_word_if                            words,
    tlj_result_if                          results,
    output int                             mismatches,
    output int                             pending
);
    import tlj_pkg::*;

    logic [LEN_W-1:0] line_lens [LINE_WORDS];
    int               line_count;
    logic [LEN_W-1:0] line_chars;
    logic [LEN_W-1:0] line_width;
    logic [NUM_W-1:0] line_first;
    logic [NUM_W-1:0] word_seq;

    tlj_result_t      placements_due [$];
    tlj_result_t      word_run [$];
    tlj_result_t      seen;
    tlj_result_t      want;

    function automatic tlj_result_t make_place(input logic [NUM_W-1:0] num,
                                               input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] sp,
                                               input logic end_f, input logic fin_f,
                                               input logic drop_f);
        tlj_result_t r;
        r.word_number   = num;
        r.placed_length = len;
        r.spaces_after  = sp;
        r.line_end      = end_f;
        r.final_line    = fin_f;
        r.too_long      = drop_f;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic string show(input tlj_result_t r);
        return $sformatf("num=%0d len=%0d sp=%0d end=%0b fin=%0b drop=%0b lor=%0b",
                         r.word_number, r.placed_length, r.spaces_after,
                         r.line_end, r.final_line, r.too_long, r.last_of_run);
    endfunction

    task automatic emit_line(input bit final_flag);
        int n;
        int extra;
        int gaps;
        int sp;
        bit last;
        n = line_count;
        if (n == 0)
            return;
        extra = (line_width >= line_chars) ? int'(line_width) - int'(line_chars) : 0;
        gaps  = n - 1;
        for (int j = 0; j < n; j++)
        begin
            last = (j + 1 == n);
            if (final_flag)
                sp = last ? ((extra >= gaps) ? extra - gaps : 0) : 1;
            else if (n == 1)
                sp = extra;
            else if (last)
                sp = 0;
            else
                sp = extra / gaps + ((j < extra % gaps) ? 1 : 0);
            word_run.insert(word_run.size(),
                            make_place(NUM_W'(int'(line_first) + j), line_lens[j],
                                       LEN_W'(sp), last, final_flag, 1'b0));
        end
        line_count = 0;
        line_chars = '0;
        line_first = word_seq;
    endtask

    task automatic justify_word(input logic [LEN_W-1:0] len, input bit last);
        word_run.delete();
        if (len == 0 || len > line_width)
        begin
            if (last)
                emit_line(1'b1);
            word_run.insert(word_run.size(),
                            make_place(word_seq, len, '0, 1'b0, 1'b0, 1'b1));
        end
        else
        begin
            if (line_count > 0 &&
                (int'(line_chars) + line_count + int'(len) > int'(line_width) ||
                 line_count >= LINE_WORDS))
                emit_line(1'b0);
            if (line_count == 0)
                line_first = word_seq;
            if (line_count < LINE_WORDS)
                line_lens[line_count] = len;
            line_count++;
            line_chars = line_chars + len;
            word_seq   = word_seq + 1'b1;
            if (last)
                emit_line(1'b1);
        end
        if (word_run.size() > 0)
            word_run[word_run.size()-1].last_of_run = 1'b1;
        foreach (word_run[i])
            placements_due.insert(placements_due.size(), word_run[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count = 0;
            line_chars = '0;
            line_width = WIDTH_RESET;
            line_first = '0;
            word_seq   = '0;
            mismatches = 0;
            placements_due.delete();
        end
        else
        begin
            if (cfg_we)
                line_width = cfg_data;
            if (results.valid && results.ready)
            begin
                seen.word_number   = results.word_number;
                seen.placed_length = results.placed_length;
                seen.spaces_after  = results.spaces_after;
                seen.line_end      = results.line_end;
                seen.final_line    = results.final_line;
                seen.too_long      = results.too_long;
                seen.last_of_run   = results.last_of_run;
                if (placements_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %s", show(seen));
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %s, actual %s",
                                     show(want), show(seen));
                    end
                end
            end
            if (words.valid && words.ready)
                justify_word(words.word_length, words.last_word);
        end
        pending = placements_due.size();
    end

endmodule

/* bench/tb_text_line_justifier_unit.sv */
// Testbench top for text_line_justifier_unit: clock, reset, word stimulus,
// width changes and result back-pressure. Checking sits in tlj_justify_checker.
// Depends on tlj_pkg, tlj_if, text_line_justifier_unit and tlj_justify_checker.

module tb_text_line_justifier_unit;
    import tlj_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES      = 10;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_data;

    int  mismatches;
    int  pending;
    int  cycle_count = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;
    int  hold = 0;

    tlj_word_if   words_ch ();
    tlj_result_if results_ch ();

    text_line_justifier_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .words    (words_ch),
        .results  (results_ch)
    );

    tlj_justify_checker i_justify_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .words      (words_ch),
        .results    (results_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short, now and then long
    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    initial
    begin
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                results_ch.ready = 1'b0;
            end
            else
            begin
                results_ch.ready = 1'b1;
                hold = pick_gap(rx_stalls);
            end
        end
    end

    task automatic push_word(input logic [LEN_W-1:0] len, input bit last, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            words_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        words_ch.valid       = 1'b1;
        words_ch.word_length = len;
        words_ch.last_word   = last;
        @(posedge clk);
        while (!words_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        words_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_width(input logic [LEN_W-1:0] w);
        drain_results();
        repeat (12) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = w;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    initial
    begin
        int               w;
        int               n;
        logic [LEN_W-1:0] len;
        bit               last;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        words_ch.valid       = 1'b0;
        words_ch.word_length = '0;
        words_ch.last_word   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at the reset width
        push_word(5, 0, pick_gap(tx_gaps));  push_word(4, 0, pick_gap(tx_gaps));
        push_word(6, 0, pick_gap(tx_gaps));  push_word(16, 0, pick_gap(tx_gaps));
        push_word(1, 0, pick_gap(tx_gaps));  push_word(17, 0, pick_gap(tx_gaps));
        push_word(0, 0, pick_gap(tx_gaps));  push_word(63, 0, pick_gap(tx_gaps));
        push_word(3, 0, pick_gap(tx_gaps));  push_word(3, 0, pick_gap(tx_gaps));
        push_word(3, 0, pick_gap(tx_gaps));  push_word(3, 0, pick_gap(tx_gaps));
        push_word(2, 1, pick_gap(tx_gaps));
        // drop carrying last_word over a buffered line, then over an empty one
        push_word(2, 0, pick_gap(tx_gaps));  push_word(0, 1, pick_gap(tx_gaps));
        push_word(20, 1, pick_gap(tx_gaps)); push_word(7, 1, pick_gap(tx_gaps));
        // uneven gap split
        push_word(1, 0, pick_gap(tx_gaps));  push_word(1, 0, pick_gap(tx_gaps));
        push_word(1, 0, pick_gap(tx_gaps));  push_word(9, 0, pick_gap(tx_gaps));
        push_word(1, 1, pick_gap(tx_gaps));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin w = 63; n = 30; end
                1: begin w = 1;  n = 20; end
                2: begin w = 0;  n = 10; end
                3: begin w = 40; n = 45; end
                4: begin w = 8;  n = 45; end
                5: begin w = 63; n = 45; end
                6: begin w = 25; n = 45; end
                7: begin w = 12; n = 45; end
                default: begin w = $urandom_range(1, 63); n = 20; end
            endcase
            set_width(LEN_W'(w));
            tx_gaps   = (p != 3);
            rx_stalls = (p != 3) && (p != 6);

            // full line buffer: 32 one-character words fill a 63 wide line
            if (p == 0)
                for (int k = 0; k < 34; k++)
                    push_word(1, (k == 33), pick_gap(tx_gaps));

            for (int k = 0; k < n; k++)
            begin
                if (w == 0 || $urandom_range(0, 99) < 12)
                begin
                    len  = ($urandom_range(0, 2) == 0) ? '0 : LEN_W'($urandom_range(0, 63));
                    last = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    if ($urandom_range(0, 1))
                        len = LEN_W'($urandom_range(1, (w > 4) ? w / 4 : 1));
                    else
                        len = LEN_W'($urandom_range(1, w));
                    last = ($urandom_range(0, 11) == 0);
                end
                push_word(len, last, pick_gap(tx_gaps));
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tlj_pkg.sv
rtl/tlj_if.sv
rtl/tlj_lbuf.sv
rtl/tlj_div.sv
rtl/text_line_justifier_unit.sv
bench/tlj_justify_checker.sv
bench/tb_text_line_justifier_unit.sv
